/* rtl/core/mlrp_pkg.sv */
// Shared constants, types and character helpers for the modem line report parser.
// Used by mlrp_conv and modem_line_report_parser; depends on nothing else.
package mlrp_pkg;

  localparam int LINE_DEPTH = 512;
  localparam int IDX_W      = $clog2(LINE_DEPTH + 1);
  localparam int ADDR_W     = $clog2(LINE_DEPTH);

  localparam int FX_W = 27;
  localparam logic [FX_W-1:0] FIX_CAP = 27'd67108864;
  localparam logic [FX_W-1:0] FIX_NEG = 27'd33554432;
  localparam logic [FX_W-1:0] FIX_MAX = 27'd33554431;

  localparam logic [25:0] LAT_RESET = 26'd4236480;
  localparam logic [25:0] LON_RESET = 26'(-26'sd7112470);

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_O     = 8'h4F;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_V     = 8'h56;

  localparam logic [1:0] KIND_OTHER = 2'd0;
  localparam logic [1:0] KIND_POS   = 2'd1;
  localparam logic [1:0] KIND_DT    = 2'd2;
  localparam logic [1:0] KIND_TX    = 2'd3;

  typedef struct packed {
    logic clr;
    logic step;
  } conv_ctl_t;

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0B || c == 8'h0C || c == 8'h0D;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic [3:0] digit_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return d[3:0];
  endfunction

endpackage

/* rtl/core/mlrp_conv.sv */
// Shared character-serial number converter: one character a cycle while
// stepped, into a saturated fixed-point magnitude and a 16-bit wrapped integer; uses mlrp_pkg.
module mlrp_conv (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mlrp_pkg::conv_ctl_t       ctl,
  input  logic [7:0]                ch,
  output logic [mlrp_pkg::FX_W-1:0] fx,
  output logic [15:0]               wv,
  output logic                      neg,
  output logic                      dot
);

  typedef enum logic [1:0] {PH_SKIP, PH_INT, PH_FRAC, PH_STOP} phase_t;

  phase_t                    phase_r, phase_nxt;
  logic [2:0]                fd_r, fd_nxt;
  logic [mlrp_pkg::FX_W-1:0] fx_r, fx_nxt;
  logic [15:0]               wv_r, wv_nxt;
  logic                      neg_r, neg_nxt, dot_r, dot_nxt;

  logic [3:0]  d;
  logic [30:0] int_sum;
  logic [27:0] frac_sum;
  logic [16:0] scale;
  logic [2:0]  fd_inc;

  always_comb begin
    d = mlrp_pkg::digit_val(ch);
    int_sum = 31'(fx_r) * 31'd10 + 31'(d) * 31'd100000;
    fd_inc = (fd_r < 3'd6) ? fd_r + 3'd1 : fd_r;
    case (fd_inc)
      3'd1:    scale = 17'd10000;
      3'd2:    scale = 17'd1000;
      3'd3:    scale = 17'd100;
      3'd4:    scale = 17'd10;
      3'd5:    scale = 17'd1;
      default: scale = 17'd0;
    endcase
    frac_sum = 28'(fx_r) + 28'(d) * 28'(scale);

    phase_nxt = phase_r;
    fd_nxt    = fd_r;
    fx_nxt    = fx_r;
    wv_nxt    = wv_r;
    neg_nxt   = neg_r;
    dot_nxt   = dot_r;
    if (ctl.clr) begin
      phase_nxt = PH_SKIP;
      fd_nxt    = 3'd0;
      fx_nxt    = '0;
      wv_nxt    = '0;
      neg_nxt   = 1'b0;
      dot_nxt   = 1'b0;
    end else if (ctl.step) begin
      if (ch == mlrp_pkg::CH_MINUS) begin
        neg_nxt = 1'b1;
      end else begin
        if (ch == mlrp_pkg::CH_DOT) begin
          dot_nxt = 1'b1;
        end
        case (phase_r)
          PH_SKIP, PH_INT: begin
            if (phase_r == PH_SKIP && mlrp_pkg::is_space(ch)) begin
              phase_nxt = PH_SKIP;
            end else if (phase_r == PH_SKIP && ch == mlrp_pkg::CH_PLUS) begin
              phase_nxt = PH_INT;
            end else if (mlrp_pkg::is_digit(ch)) begin
              phase_nxt = PH_INT;
              wv_nxt = 16'(wv_r * 16'd10 + 16'(d));
              fx_nxt = (int_sum > 31'(mlrp_pkg::FIX_CAP)) ? mlrp_pkg::FIX_CAP
                                                          : int_sum[mlrp_pkg::FX_W-1:0];
            end else if (ch == mlrp_pkg::CH_DOT) begin
              phase_nxt = PH_FRAC;
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          PH_FRAC: begin
            if (mlrp_pkg::is_digit(ch)) begin
              fd_nxt = fd_inc;
              if (fd_inc <= 3'd5) begin
                fx_nxt = (frac_sum > 28'(mlrp_pkg::FIX_CAP)) ? mlrp_pkg::FIX_CAP
                                                             : frac_sum[mlrp_pkg::FX_W-1:0];
              end
            end else begin
              phase_nxt = PH_STOP;
            end
          end
          default: phase_nxt = PH_STOP;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      fd_r    <= 3'd0;
      fx_r    <= '0;
      wv_r    <= '0;
      neg_r   <= 1'b0;
      dot_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fd_r    <= fd_nxt;
      fx_r    <= fx_nxt;
      wv_r    <= wv_nxt;
      neg_r   <= neg_nxt;
      dot_r   <= dot_nxt;
    end
  end

  assign fx  = fx_r;
  assign wv  = wv_r;
  assign neg = neg_r;
  assign dot = dot_r;

endmodule

/* rtl/core/modem_line_report_parser.sv */
// Top level of the modem line report parser: line store, parse sequencer and
// result register. Uses mlrp_pkg and the shared converter mlrp_conv.
//
//   channel | direction | handshake      | payload
//   in_     | input     | valid / stall  | in_rx_byte
//   out_    | output    | valid / stall  | out_line_kind ... out_second
//   cfg_    | input     | valid / ready  | cfg_data (enable)
//
// An ordinary byte is written to the line store as it is accepted. A newline
// starts classification through the single line store read port, then a scan
// from offset 4 up to the star or the line end for a position line, or six
// character pairs from offset 6 for a datetime line; then the result is loaded.
// The input is stalled while a line is parsed and while a finished result
// waits behind a stalled output. Reset is synchronous; the line store is not
// cleared, since only bytes of the current line are ever read.
module modem_line_report_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_line_kind,
  output logic signed [25:0] out_latitude,
  output logic signed [25:0] out_longitude,
  output logic [15:0] out_altitude,
  output logic [15:0] out_course,
  output logic [15:0] out_speed,
  output logic [6:0]  out_year_of_century,
  output logic [6:0]  out_month,
  output logic [6:0]  out_day,
  output logic [6:0]  out_hour,
  output logic [6:0]  out_minute,
  output logic [6:0]  out_second,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  localparam int IW = mlrp_pkg::IDX_W;
  localparam int AW = mlrp_pkg::ADDR_W;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_C1, S_C2, S_C4, S_CV, S_PSCAN, S_DA, S_DB, S_DONE
  } state_t;

  logic [7:0] line_mem [mlrp_pkg::LINE_DEPTH];

  state_t      state_r, state_nxt;
  logic [IW-1:0] wr_idx_r, wr_idx_nxt, len_r, len_nxt, pos_r, pos_nxt;
  logic        enable_r, enable_nxt;
  logic [1:0]  slot_r, slot_nxt, kind_r, kind_nxt;
  logic [2:0]  jdx_r, jdx_nxt;
  logic        fempty_r, fempty_nxt, ack_r, ack_nxt;
  logic [7:0]  ch1_r, ch1_nxt, ch2_r, ch2_nxt, ch4_r, ch4_nxt, cha_r, cha_nxt;
  logic [25:0] lat_r, lat_nxt, lon_r, lon_nxt;
  logic [15:0] ints_r [3];
  logic [15:0] ints_nxt [3];
  logic [6:0]  dt_r [6];
  logic [6:0]  dt_nxt [6];
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  o_kind_r, o_kind_nxt;
  logic [25:0] o_lat_r, o_lat_nxt, o_lon_r, o_lon_nxt;
  logic [15:0] o_ints_r [3];
  logic [15:0] o_ints_nxt [3];
  logic [6:0]  o_dt_r [6];
  logic [6:0]  o_dt_nxt [6];

  logic [IW-1:0] rd_addr;
  logic [7:0]    rd_data_r;
  logic          rd_ok_r;
  logic [7:0]    ch;
  logic          mem_we;

  mlrp_pkg::conv_ctl_t       cv_ctl;
  logic [mlrp_pkg::FX_W-1:0] cv_fx;
  logic [15:0]               cv_wv;
  logic                      cv_neg, cv_dot;
  logic [25:0]               fix_val;

  mlrp_conv u_conv (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cv_ctl),
    .ch    (ch),
    .fx    (cv_fx),
    .wv    (cv_wv),
    .neg   (cv_neg),
    .dot   (cv_dot)
  );

  // Two-character atoi, wrapped to seven bits.
  function automatic logic [6:0] dt_pair(input logic [7:0] a, input logic [7:0] b);
    logic [6:0] v;
    logic       ng;
    v  = 7'd0;
    ng = 1'b0;
    if (mlrp_pkg::is_space(a)) begin
      if (mlrp_pkg::is_digit(b)) v = 7'(mlrp_pkg::digit_val(b));
    end else if (a == mlrp_pkg::CH_PLUS || a == mlrp_pkg::CH_MINUS) begin
      ng = (a == mlrp_pkg::CH_MINUS);
      if (mlrp_pkg::is_digit(b)) v = 7'(mlrp_pkg::digit_val(b));
    end else if (mlrp_pkg::is_digit(a)) begin
      if (mlrp_pkg::is_digit(b)) begin
        v = 7'(7'(mlrp_pkg::digit_val(a)) * 7'd10 + 7'(mlrp_pkg::digit_val(b)));
      end else begin
        v = 7'(mlrp_pkg::digit_val(a));
      end
    end
    return ng ? 7'd0 - v : v;
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[wr_idx_r[AW-1:0]] <= in_rx_byte;
    end
    rd_data_r <= line_mem[rd_addr[AW-1:0]];
    rd_ok_r   <= rd_addr < len_r;
  end

  assign ch = rd_ok_r ? rd_data_r : 8'd0;

  always_comb begin
    if (cv_neg) begin
      fix_val = (cv_fx >= mlrp_pkg::FIX_NEG) ? 26'(-26'sd33554432)
                                             : 26'd0 - {1'b0, cv_fx[24:0]};
    end else begin
      fix_val = (cv_fx > mlrp_pkg::FIX_MAX) ? mlrp_pkg::FIX_MAX[25:0] : cv_fx[25:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    enable_nxt    = enable_r;
    slot_nxt      = slot_r;
    kind_nxt      = kind_r;
    jdx_nxt       = jdx_r;
    fempty_nxt    = fempty_r;
    ack_nxt       = ack_r;
    ch1_nxt       = ch1_r;
    ch2_nxt       = ch2_r;
    ch4_nxt       = ch4_r;
    cha_nxt       = cha_r;
    lat_nxt       = lat_r;
    lon_nxt       = lon_r;
    ints_nxt      = ints_r;
    dt_nxt        = dt_r;
    out_valid_nxt = out_valid_r;
    o_kind_nxt    = o_kind_r;
    o_lat_nxt     = o_lat_r;
    o_lon_nxt     = o_lon_r;
    o_ints_nxt    = o_ints_r;
    o_dt_nxt      = o_dt_r;
    rd_addr       = '0;
    mem_we        = 1'b0;
    cv_ctl        = '0;

    if (cfg_valid) enable_nxt = cfg_data;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && enable_r) begin
          if (in_rx_byte == mlrp_pkg::CH_NL) begin
            len_nxt    = wr_idx_r;
            wr_idx_nxt = '0;
            state_nxt  = S_START;
          end else if (wr_idx_r < IW'(mlrp_pkg::LINE_DEPTH)) begin
            mem_we     = 1'b1;
            wr_idx_nxt = wr_idx_r + IW'(1);
          end
        end
      end
      S_START: begin
        rd_addr   = IW'(1);
        state_nxt = S_C1;
      end
      S_C1: begin
        ch1_nxt   = ch;
        rd_addr   = IW'(2);
        state_nxt = S_C2;
      end
      S_C2: begin
        ch2_nxt   = ch;
        rd_addr   = IW'(4);
        state_nxt = S_C4;
      end
      S_C4: begin
        ch4_nxt   = ch;
        rd_addr   = len_r - IW'(4);
        state_nxt = S_CV;
      end
      S_CV: begin
        if (ch2_r == mlrp_pkg::CH_N && ch4_r != mlrp_pkg::CH_E && ch4_r != mlrp_pkg::CH_O) begin
          rd_addr    = IW'(4);
          pos_nxt    = IW'(4);
          slot_nxt   = 2'd0;
          fempty_nxt = 1'b1;
          cv_ctl.clr = 1'b1;
          kind_nxt   = mlrp_pkg::KIND_POS;
          state_nxt  = S_PSCAN;
        end else if (ch1_r == mlrp_pkg::CH_D && len_r >= IW'(4) && ch == mlrp_pkg::CH_V) begin
          rd_addr   = IW'(6);
          pos_nxt   = IW'(6);
          jdx_nxt   = 3'd0;
          kind_nxt  = mlrp_pkg::KIND_DT;
          state_nxt = S_DA;
        end else if (ch1_r == mlrp_pkg::CH_T && ch4_r == mlrp_pkg::CH_S) begin
          kind_nxt  = ack_r ? mlrp_pkg::KIND_TX : mlrp_pkg::KIND_OTHER;
          state_nxt = S_DONE;
        end else begin
          kind_nxt  = mlrp_pkg::KIND_OTHER;
          state_nxt = S_DONE;
        end
      end
      S_PSCAN: begin
        rd_addr = pos_r + IW'(1);
        if (!rd_ok_r || ch == mlrp_pkg::CH_STAR || ch == mlrp_pkg::CH_COMMA) begin
          // An empty field before the line end or star is not a field at all.
          if (ch == mlrp_pkg::CH_COMMA || !fempty_r) begin
            if (cv_dot) begin
              if (slot_r == 2'd0) lat_nxt = fix_val;
              else if (slot_r == 2'd1) lon_nxt = fix_val;
            end else if (slot_r != 2'd3) begin
              ints_nxt[slot_r] = cv_neg ? 16'd0 - cv_wv : cv_wv;
            end
          end
          if (rd_ok_r && ch == mlrp_pkg::CH_COMMA) begin
            if (cv_dot && slot_r == 2'd1) slot_nxt = 2'd0;
            else if (slot_r != 2'd3) slot_nxt = slot_r + 2'd1;
            ack_nxt    = 1'b1;
            cv_ctl.clr = 1'b1;
            fempty_nxt = 1'b1;
            pos_nxt    = pos_r + IW'(1);
          end else begin
            state_nxt = S_DONE;
          end
        end else begin
          cv_ctl.step = 1'b1;
          fempty_nxt  = 1'b0;
          pos_nxt     = pos_r + IW'(1);
        end
      end
      S_DA: begin
        cha_nxt   = ch;
        rd_addr   = pos_r + IW'(1);
        state_nxt = S_DB;
      end
      S_DB: begin
        dt_nxt[jdx_r] = dt_pair(cha_r, ch);
        if (jdx_r == 3'd5) begin
          state_nxt = S_DONE;
        end else begin
          rd_addr   = pos_r + IW'(2);
          pos_nxt   = pos_r + IW'(2);
          jdx_nxt   = jdx_r + 3'd1;
          state_nxt = S_DA;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = kind_r;
          o_lat_nxt     = lat_r;
          o_lon_nxt     = lon_r;
          o_ints_nxt    = ints_r;
          o_dt_nxt      = dt_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      len_r       <= '0;
      enable_r    <= 1'b0;
      ack_r       <= 1'b0;
      lat_r       <= mlrp_pkg::LAT_RESET;
      lon_r       <= mlrp_pkg::LON_RESET;
      ints_r      <= '{default: 16'd0};
      dt_r        <= '{7'd70, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0};
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      slot_r      <= 2'd0;
      jdx_r       <= 3'd0;
      fempty_r    <= 1'b1;
      kind_r      <= mlrp_pkg::KIND_OTHER;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      len_r       <= len_nxt;
      enable_r    <= enable_nxt;
      ack_r       <= ack_nxt;
      lat_r       <= lat_nxt;
      lon_r       <= lon_nxt;
      ints_r      <= ints_nxt;
      dt_r        <= dt_nxt;
      out_valid_r <= out_valid_nxt;
      pos_r       <= pos_nxt;
      slot_r      <= slot_nxt;
      jdx_r       <= jdx_nxt;
      fempty_r    <= fempty_nxt;
      kind_r      <= kind_nxt;
    end
    ch1_r    <= ch1_nxt;
    ch2_r    <= ch2_nxt;
    ch4_r    <= ch4_nxt;
    cha_r    <= cha_nxt;
    o_kind_r <= o_kind_nxt;
    o_lat_r  <= o_lat_nxt;
    o_lon_r  <= o_lon_nxt;
    o_ints_r <= o_ints_nxt;
    o_dt_r   <= o_dt_nxt;
  end

  assign in_stall            = (state_r != S_IDLE);
  assign cfg_ready           = 1'b1;
  assign out_valid           = out_valid_r;
  assign out_line_kind       = o_kind_r;
  assign out_latitude        = o_lat_r;
  assign out_longitude       = o_lon_r;
  assign out_altitude        = o_ints_r[0];
  assign out_course          = o_ints_r[1];
  assign out_speed           = o_ints_r[2];
  assign out_year_of_century = o_dt_r[0];
  assign out_month           = o_dt_r[1];
  assign out_day             = o_dt_r[2];
  assign out_hour            = o_dt_r[3];
  assign out_minute          = o_dt_r[4];
  assign out_second          = o_dt_r[5];

`ifndef ASSERT_OFF
  a_wr_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wr_idx_r <= IW'(mlrp_pkg::LINE_DEPTH))
    else $error("line store write index beyond depth");

  // A position line shorter than four bytes starts its scan beyond the line end.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_PSCAN |-> (pos_r <= len_r || pos_r == IW'(4)))
    else $error("position scan ran past the line end");

  a_nl_starts_parse: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && enable_r && in_rx_byte == mlrp_pkg::CH_NL) |=> in_stall)
    else $error("newline transaction did not start a parse");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result appeared outside the load step");
`endif

endmodule
